@@ rtl/rc6_pkg.sv @@
// rc6_pkg: shared constants, controller states and the command/status
// structs that join the rc6 controller and datapath
// no dependencies
package rc6_pkg;

    localparam int DEF_ROUND_COUNT = 20;
    localparam int DEF_KEY_BYTES   = 32;

    localparam int WORD_W      = 32;
    localparam int KEY_REG_W   = 64;
    localparam int KEY_REG_NUM = 4;
    localparam int CFG_INDEX_W = 2;

    localparam logic [WORD_W-1:0] MAGIC_P = 32'hB7E15163;
    localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9E3779B9;

    typedef enum logic [2:0] {
        ST_KS_INIT,
        ST_KS_STEP,
        ST_IDLE,
        ST_BLK_RD,
        ST_WHITEN,
        ST_ROUND,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic ks_init;
        logic ks_step;
        logic ks_first;
        logic blk_load;
        logic rd_adv;
        logic whiten_in;
        logic round;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic key_wr;
        logic out_free;
    } status_t;

endpackage

@@ rtl/rc6_block_cipher.sv @@
// rc6_block_cipher: top level of the rc6 block cipher
// depends on rc6_pkg, rc6_ctrl and rc6_dpath
//
// Encrypts (s_mode 0) or decrypts (s_mode 1) one 128-bit block of four
// 32-bit words per beat with a key of KEY_BYTES bytes held in four 64-bit
// registers. Every key write starts the key expansion again, which runs
// with s_ready low; the expansion also runs once after reset. A block runs
// one round per cycle through a single round unit, with the round keys read
// from a two-port key ram in the cycle before they are used, and its result
// goes to the output register. A new block is accepted only after the
// previous one is through; a result still held in the output register
// stretches the last cycle of the following block until it is taken. A new
// block is accepted while an earlier result waits in the output register.
module rc6_block_cipher #(
    parameter int ROUND_COUNT = rc6_pkg::DEF_ROUND_COUNT,
    parameter int KEY_BYTES   = rc6_pkg::DEF_KEY_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rc6_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rc6_pkg::KEY_REG_W-1:0]   cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [rc6_pkg::WORD_W-1:0]      s_in_word_a,
    input  logic [rc6_pkg::WORD_W-1:0]      s_in_word_b,
    input  logic [rc6_pkg::WORD_W-1:0]      s_in_word_c,
    input  logic [rc6_pkg::WORD_W-1:0]      s_in_word_d,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rc6_pkg::WORD_W-1:0]      m_out_word_a,
    output logic [rc6_pkg::WORD_W-1:0]      m_out_word_b,
    output logic [rc6_pkg::WORD_W-1:0]      m_out_word_c,
    output logic [rc6_pkg::WORD_W-1:0]      m_out_word_d
);

    rc6_pkg::cmd_t    cmd;
    rc6_pkg::status_t status;

    rc6_ctrl #(
        .ROUND_COUNT (ROUND_COUNT),
        .KEY_BYTES   (KEY_BYTES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rc6_dpath #(
        .ROUND_COUNT (ROUND_COUNT),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_mode       (s_mode),
        .s_in_word_a  (s_in_word_a),
        .s_in_word_b  (s_in_word_b),
        .s_in_word_c  (s_in_word_c),
        .s_in_word_d  (s_in_word_d),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_word_a (m_out_word_a),
        .m_out_word_b (m_out_word_b),
        .m_out_word_c (m_out_word_c),
        .m_out_word_d (m_out_word_d),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

@@ rtl/rc6_ram.sv @@
// rc6_ram: generic ram, one write port and two registered read ports
// no dependencies
module rc6_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    output logic [WIDTH-1:0]         rdata0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

@@ rtl/rc6_ctrl.sv @@
// rc6_ctrl: controller fsm sequencing key expansion and block rounds
// depends on rc6_pkg
module rc6_ctrl #(
    parameter int ROUND_COUNT = rc6_pkg::DEF_ROUND_COUNT,
    parameter int KEY_BYTES   = rc6_pkg::DEF_KEY_BYTES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rc6_pkg::status_t  status,
    output rc6_pkg::cmd_t     cmd
);

    localparam int RK     = 2 * ROUND_COUNT + 4;
    localparam int KW     = (KEY_BYTES + 3) / 4;
    localparam int STEPS  = 3 * ((RK > KW) ? RK : KW);
    localparam int STEP_W = $clog2(STEPS);
    localparam int RND_W  = $clog2(ROUND_COUNT + 1);

    rc6_pkg::state_t   state_reg, state_next;
    logic [STEP_W-1:0] step_cnt_reg, step_cnt_next;
    logic [RND_W-1:0]  rnd_cnt_reg, rnd_cnt_next;
    logic              last_round;

    assign last_round = (rnd_cnt_reg == RND_W'(ROUND_COUNT - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rc6_pkg::ST_KS_INIT;
            step_cnt_reg <= '0;
            rnd_cnt_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
            rnd_cnt_reg  <= rnd_cnt_next;
        end
    end

    // next state and counters
    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        rnd_cnt_next  = rnd_cnt_reg;
        case (state_reg)
            rc6_pkg::ST_KS_INIT: begin
                step_cnt_next = '0;
                state_next    = rc6_pkg::ST_KS_STEP;
            end
            rc6_pkg::ST_KS_STEP: begin
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_W'(STEPS - 1)) begin
                    state_next = rc6_pkg::ST_IDLE;
                end
            end
            rc6_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rc6_pkg::ST_BLK_RD;
                end
            end
            rc6_pkg::ST_BLK_RD: begin
                rnd_cnt_next = '0;
                state_next   = rc6_pkg::ST_WHITEN;
            end
            rc6_pkg::ST_WHITEN: begin
                state_next = rc6_pkg::ST_ROUND;
            end
            rc6_pkg::ST_ROUND: begin
                rnd_cnt_next = rnd_cnt_reg + 1'b1;
                if (last_round) begin
                    state_next = rc6_pkg::ST_FINAL;
                end
            end
            rc6_pkg::ST_FINAL: begin
                if (status.out_free) begin
                    state_next = rc6_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rc6_pkg::ST_KS_INIT;
            end
        endcase
        // a key write always restarts the expansion
        if (status.key_wr) begin
            state_next = rc6_pkg::ST_KS_INIT;
        end
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            rc6_pkg::ST_KS_INIT: begin
                cmd.ks_init = 1'b1;
            end
            rc6_pkg::ST_KS_STEP: begin
                cmd.ks_step  = 1'b1;
                cmd.ks_first = (step_cnt_reg < STEP_W'(RK));
            end
            rc6_pkg::ST_IDLE: begin
                s_ready      = !status.key_wr;
                cmd.blk_load = s_valid && !status.key_wr;
            end
            rc6_pkg::ST_BLK_RD: begin
                cmd.rd_adv = 1'b1;
            end
            rc6_pkg::ST_WHITEN: begin
                cmd.whiten_in = 1'b1;
                cmd.rd_adv    = 1'b1;
            end
            rc6_pkg::ST_ROUND: begin
                cmd.round  = 1'b1;
                cmd.rd_adv = !last_round;
            end
            rc6_pkg::ST_FINAL: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == rc6_pkg::ST_IDLE))
        else $error("input ready outside idle");

    a_accept_starts_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == rc6_pkg::ST_BLK_RD))
        else $error("accepted beat did not start a block");

    a_key_write_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        status.key_wr |=> (state_reg == rc6_pkg::ST_KS_INIT))
        else $error("key write did not restart expansion");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rc6_pkg::ST_KS_STEP) |-> (step_cnt_reg <= STEP_W'(STEPS - 1)))
        else $error("schedule step counter out of range");

    a_round_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rc6_pkg::ST_ROUND) |-> (rnd_cnt_reg <= RND_W'(ROUND_COUNT - 1)))
        else $error("round counter out of range");

endmodule

@@ rtl/rc6_dpath.sv @@
// rc6_dpath: key registers, key schedule, round key ram, round logic
// and output register; depends on rc6_pkg and rc6_ram
module rc6_dpath #(
    parameter int ROUND_COUNT = rc6_pkg::DEF_ROUND_COUNT,
    parameter int KEY_BYTES   = rc6_pkg::DEF_KEY_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rc6_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rc6_pkg::KEY_REG_W-1:0]   cfg_wdata,
    input  logic                            s_mode,
    input  logic [rc6_pkg::WORD_W-1:0]      s_in_word_a,
    input  logic [rc6_pkg::WORD_W-1:0]      s_in_word_b,
    input  logic [rc6_pkg::WORD_W-1:0]      s_in_word_c,
    input  logic [rc6_pkg::WORD_W-1:0]      s_in_word_d,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rc6_pkg::WORD_W-1:0]      m_out_word_a,
    output logic [rc6_pkg::WORD_W-1:0]      m_out_word_b,
    output logic [rc6_pkg::WORD_W-1:0]      m_out_word_c,
    output logic [rc6_pkg::WORD_W-1:0]      m_out_word_d,
    input  rc6_pkg::cmd_t                   cmd,
    output rc6_pkg::status_t                status
);

    localparam int W        = rc6_pkg::WORD_W;
    localparam int RK       = 2 * ROUND_COUNT + 4;
    localparam int KW       = (KEY_BYTES + 3) / 4;
    localparam int ADDR_W   = $clog2(RK);
    localparam int PAIR_W   = ADDR_W - 1;
    localparam int LI_W     = $clog2(KW);
    localparam int KEY_ALL  = rc6_pkg::KEY_REG_W * rc6_pkg::KEY_REG_NUM;
    localparam logic [4:0] ROT_KEY   = 5'd3;
    localparam logic [4:0] ROT_FIXED = 5'd5;

    function automatic logic [W-1:0] rotl(input logic [W-1:0] x, input logic [4:0] s);
        logic [2*W-1:0] w;
        w = {x, x} << s;
        return w[2*W-1:W];
    endfunction

    function automatic logic [W-1:0] rotr(input logic [W-1:0] x, input logic [4:0] s);
        logic [2*W-1:0] w;
        w = {x, x} >> s;
        return w[W-1:0];
    endfunction

    logic [rc6_pkg::KEY_REG_W-1:0] key_reg [rc6_pkg::KEY_REG_NUM];
    logic [KEY_ALL-1:0]            key_all;
    logic [W-1:0]                  l_init [KW];

    logic [W-1:0]      l_reg [KW];
    logic [W-1:0]      x_reg, y_reg, acc_reg;
    logic [ADDR_W-1:0] ri_reg, ri_next;
    logic [LI_W-1:0]   li_reg, li_next;
    logic [W-1:0]      s_val, ks_sum, x_new, xy_sum, y_new;

    logic [W-1:0]      a_reg, b_reg, c_reg, d_reg;
    logic              mode_reg;
    logic [PAIR_W-1:0] pair_reg;

    logic [ADDR_W-1:0] raddr0, raddr1;
    logic [W-1:0]      k0, k1;

    logic [W-1:0] mul_b, mul_d, prod_t, prod_u, t_val, u_val;
    logic [W-1:0] enc_a, enc_c, dec_a, dec_c;
    logic [W-1:0] fin_a, fin_b, fin_c, fin_d;

    logic         m_valid_reg;
    logic [W-1:0] out_a_reg, out_b_reg, out_c_reg, out_d_reg;

    // key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rc6_pkg::KEY_REG_NUM; i++) begin
                key_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            key_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_comb begin
        for (int i = 0; i < rc6_pkg::KEY_REG_NUM; i++) begin
            key_all[i*rc6_pkg::KEY_REG_W +: rc6_pkg::KEY_REG_W] = key_reg[i];
        end
    end

    // key bytes beyond the key length read as zero
    always_comb begin
        for (int w = 0; w < KW; w++) begin
            for (int j = 0; j < 4; j++) begin
                if (4 * w + j < KEY_BYTES) begin
                    l_init[w][8*j +: 8] = key_all[8*(4*w+j) +: 8];
                end else begin
                    l_init[w][8*j +: 8] = 8'h00;
                end
            end
        end
    end

    // key schedule step
    assign ri_next = (ri_reg == ADDR_W'(RK - 1)) ? '0 : ri_reg + 1'b1;
    assign li_next = (li_reg == LI_W'(KW - 1)) ? '0 : li_reg + 1'b1;
    assign s_val   = cmd.ks_first ? acc_reg : k0;
    assign ks_sum  = s_val + x_reg + y_reg;
    assign x_new   = rotl(ks_sum, ROT_KEY);
    assign xy_sum  = x_new + y_reg;
    assign y_new   = rotl(l_reg[li_reg] + xy_sum, xy_sum[4:0]);

    always_ff @(posedge aclk) begin
        if (cmd.ks_init) begin
            x_reg   <= '0;
            y_reg   <= '0;
            acc_reg <= rc6_pkg::MAGIC_P;
            ri_reg  <= '0;
            li_reg  <= '0;
            for (int i = 0; i < KW; i++) begin
                l_reg[i] <= l_init[i];
            end
        end else if (cmd.ks_step) begin
            x_reg          <= x_new;
            y_reg          <= y_new;
            acc_reg        <= acc_reg + rc6_pkg::MAGIC_Q;
            ri_reg         <= ri_next;
            li_reg         <= li_next;
            l_reg[li_reg]  <= y_new;
        end
    end

    // round key ram, reads issued in the cycle before the keys are used
    assign raddr0 = cmd.ks_step ? ri_next : {pair_reg, 1'b0};
    assign raddr1 = {pair_reg, 1'b1};

    rc6_ram #(
        .WIDTH (W),
        .DEPTH (RK)
    ) u_rk_ram (
        .aclk   (aclk),
        .we     (cmd.ks_step),
        .waddr  (ri_reg),
        .wdata  (x_new),
        .raddr0 (raddr0),
        .rdata0 (k0),
        .raddr1 (raddr1),
        .rdata1 (k1)
    );

    // round logic, shared by encrypt and decrypt
    assign mul_b  = mode_reg ? a_reg : b_reg;
    assign mul_d  = mode_reg ? c_reg : d_reg;
    assign prod_t = mul_b * {mul_b[W-2:0], 1'b1};
    assign prod_u = mul_d * {mul_d[W-2:0], 1'b1};
    assign t_val  = rotl(prod_t, ROT_FIXED);
    assign u_val  = rotl(prod_u, ROT_FIXED);
    assign enc_a  = rotl(a_reg ^ t_val, u_val[4:0]) + k0;
    assign enc_c  = rotl(c_reg ^ u_val, t_val[4:0]) + k1;
    assign dec_c  = rotr(b_reg - k1, t_val[4:0]) ^ u_val;
    assign dec_a  = rotr(d_reg - k0, u_val[4:0]) ^ t_val;

    assign fin_a = mode_reg ? a_reg : a_reg + k0;
    assign fin_b = mode_reg ? b_reg - k0 : b_reg;
    assign fin_c = mode_reg ? c_reg : c_reg + k1;
    assign fin_d = mode_reg ? d_reg - k1 : d_reg;

    always_ff @(posedge aclk) begin
        if (cmd.blk_load) begin
            mode_reg <= s_mode;
            a_reg    <= s_in_word_a;
            b_reg    <= s_in_word_b;
            c_reg    <= s_in_word_c;
            d_reg    <= s_in_word_d;
            pair_reg <= s_mode ? PAIR_W'(ROUND_COUNT + 1) : '0;
        end else begin
            if (cmd.rd_adv) begin
                pair_reg <= mode_reg ? pair_reg - 1'b1 : pair_reg + 1'b1;
            end
            if (cmd.whiten_in) begin
                if (mode_reg) begin
                    a_reg <= a_reg - k0;
                    c_reg <= c_reg - k1;
                end else begin
                    b_reg <= b_reg + k0;
                    d_reg <= d_reg + k1;
                end
            end else if (cmd.round) begin
                if (mode_reg) begin
                    a_reg <= dec_a;
                    b_reg <= a_reg;
                    c_reg <= dec_c;
                    d_reg <= c_reg;
                end else begin
                    a_reg <= b_reg;
                    b_reg <= enc_c;
                    c_reg <= d_reg;
                    d_reg <= enc_a;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_a_reg <= fin_a;
            out_b_reg <= fin_b;
            out_c_reg <= fin_c;
            out_d_reg <= fin_d;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_word_a = out_a_reg;
    assign m_out_word_b = out_b_reg;
    assign m_out_word_c = out_c_reg;
    assign m_out_word_d = out_d_reg;

    assign status.key_wr   = cfg_wr_en;
    assign status.out_free = !m_valid_reg || m_ready;

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");

    a_ri_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ks_step |-> (ri_reg <= ADDR_W'(RK - 1)))
        else $error("round key index out of range");

    a_li_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ks_step |-> (li_reg <= LI_W'(KW - 1)))
        else $error("key word index out of range");

endmodule
